// ----- src/twai_pkg.sv -----
package twai_pkg;

  localparam int WINDOW    = 16;
  localparam int PTR_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W     = $clog2(WINDOW + 1);
  localparam int CMP_W     = (CNT_W > 5) ? CNT_W : 5;

  localparam int SMP_W     = 16;
  localparam int STAMP_W   = 32;
  localparam int LEN_W     = 5;
  localparam int CNT_OUT_W = 5;
  localparam int DT_W      = 16;
  localparam int RES_W     = 41;

  // At most 16 samples of 16 bits are summed.
  localparam int SUM_W     = SMP_W + LEN_W;
  localparam int MAG_W     = SUM_W - 1;
  localparam int PROD_W    = MAG_W + DT_W;
  localparam int FRAC_W    = 16;
  localparam int DVD_W     = PROD_W + FRAC_W;
  localparam int DIV_W     = 15;
  localparam int MS_PER_S  = 1000;

  // The quotient is the mean times dt times 65.536, which stays below 2^38.
  localparam int Q_W       = 38;
  localparam int DIV_STEPS = Q_W / 2;
  localparam int STEP_CW   = $clog2(DIV_STEPS);

  localparam logic [DT_W-1:0] DT_MAX = {DT_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LAST,
    ST_MUL,
    ST_DIVS,
    ST_DIVW,
    ST_FIN
  } seq_state_t;

  typedef struct packed {
    logic              wr;
    logic [PTR_W-1:0]  wr_addr;
    logic [PTR_W-1:0]  rd_addr;
    logic              clr;
    logic              acc;
    logic              mul;
    logic              div_start;
    logic [DT_W-1:0]   dt;
    logic [DIV_W-1:0]  divisor;
  } lane_ctrl_t;

  typedef struct packed {
    logic                 ready;
    logic                 load;
    logic                 zero;
    logic                 full;
    logic [CNT_OUT_W-1:0] count;
  } seq_stat_t;

endpackage

// ----- src/three_axis_window_average_integrator.sv -----
// Channel   Dir  Handshake                  Content
// s_*       in   s_tvalid / s_tready        sample_x, sample_y, sample_z, stamp_ms
// m_*       out  m_tvalid / m_tready        incr_x, incr_y, incr_z, window_full, stored_count
// cfg_*     in   cfg_valid / cfg_ready      avg_len
//
// An item is processed in steps: the window memory is read one entry a cycle per lane
// for the n samples averaged, then the product is formed and the divider yields two
// quotient bits a cycle. With a single stored sample those steps are skipped.
// Reset clears the fill count, the last timestamp and sets avg_len to 1.
// The output register lets a new request in while the last result waits on m_tready.
module three_axis_window_average_integrator (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [79:0]  s_tdata,   // sample_x[15:0], sample_y[31:16], sample_z[47:32],
                                  // stamp_ms[79:48]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [135:0] m_tdata,   // incr_x[40:0], incr_y[81:41], incr_z[122:82],
                                  // window_full[123], stored_count[128:124], zero fill
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [4:0]   cfg_data
);
  import twai_pkg::*;

  logic [LEN_W-1:0] avg_len;
  lane_ctrl_t       ctrl;
  seq_stat_t        stat;
  logic             out_free;
  logic             done_x;
  logic             done_y;
  logic             done_z;

  logic signed [RES_W-1:0] res_x;
  logic signed [RES_W-1:0] res_y;
  logic signed [RES_W-1:0] res_z;
  logic signed [RES_W-1:0] incr_x;
  logic signed [RES_W-1:0] incr_y;
  logic signed [RES_W-1:0] incr_z;
  logic                    window_full;
  logic [CNT_OUT_W-1:0]    stored_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      avg_len <= LEN_W'(1);
    end else if (cfg_valid) begin
      avg_len <= cfg_data;
    end
  end

  twai_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .stamp    (s_tdata[79:48]),
    .avg_len  (avg_len),
    .div_done (done_x),
    .out_free (out_free),
    .ctrl     (ctrl),
    .stat     (stat)
  );

  assign s_tready = stat.ready;

  twai_lane u_lane_x (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .sample (s_tdata[15:0]),
    .result (res_x),
    .done   (done_x)
  );

  twai_lane u_lane_y (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .sample (s_tdata[31:16]),
    .result (res_y),
    .done   (done_y)
  );

  twai_lane u_lane_z (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .sample (s_tdata[47:32]),
    .result (res_z),
    .done   (done_z)
  );

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (stat.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // The x axis is reported with its sign flipped.
  always_ff @(posedge clk) begin
    if (stat.load) begin
      incr_x       <= stat.zero ? '0 : -res_x;
      incr_y       <= stat.zero ? '0 : res_y;
      incr_z       <= stat.zero ? '0 : res_z;
      window_full  <= stat.full;
      stored_count <= stat.count;
    end
  end

  assign m_tdata = {7'd0, stored_count, window_full, incr_z, incr_y, incr_x};

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second request taken while an item is in progress");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[123]) |-> (m_tdata[128:124] == CNT_OUT_W'(WINDOW)))
    else $error("window_full reported with a wrong stored count");

  a_stays_full: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tdata[123]) |=> stat.full)
    else $error("fill count dropped after the window was full");

  a_lanes_agree: assert property (@(posedge clk) disable iff (rst)
    done_x |-> (done_y && done_z))
    else $error("lane dividers out of step");

endmodule

// ----- src/twai_div.sv -----
module twai_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [twai_pkg::DVD_W-1:0]  dividend,
  input  logic [twai_pkg::DIV_W-1:0]  divisor,
  output logic [twai_pkg::Q_W-1:0]    quotient,
  output logic                        done
);
  import twai_pkg::*;

  logic [DIV_W-1:0]   rem;
  logic [DIV_W-1:0]   rem_next;
  logic [DIV_W-1:0]   dvs;
  logic [Q_W-1:0]     sh;
  logic [Q_W-1:0]     sh_next;
  logic [STEP_CW-1:0] cnt;
  logic               busy;

  // Two restoring steps per cycle.
  always_comb begin
    logic [DIV_W:0] r1;
    logic [DIV_W:0] t1;
    logic [DIV_W:0] r2;
    logic [DIV_W:0] t2;
    logic           ge1;
    logic           ge2;
    logic [Q_W-1:0] sh1;
    r1  = {rem, sh[Q_W-1]};
    ge1 = (r1 >= {1'b0, dvs});
    t1  = ge1 ? (r1 - {1'b0, dvs}) : r1;
    sh1 = {sh[Q_W-2:0], ge1};
    r2  = {t1[DIV_W-1:0], sh1[Q_W-1]};
    ge2 = (r2 >= {1'b0, dvs});
    t2  = ge2 ? (r2 - {1'b0, dvs}) : r2;
    sh_next  = {sh1[Q_W-2:0], ge2};
    rem_next = t2[DIV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == STEP_CW'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // The upper dividend bits are known to lie below the divisor.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= DIV_W'(dividend[DVD_W-1:Q_W]);
      sh  <= dividend[Q_W-1:0];
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      sh  <= sh_next;
    end
  end

  assign quotient = sh;
  assign done     = busy && (cnt == STEP_CW'(DIV_STEPS - 1));

endmodule

// ----- src/twai_lane.sv -----
module twai_lane (
  input  logic                              clk,
  input  logic                              rst,
  input  twai_pkg::lane_ctrl_t              ctrl,
  input  logic signed [twai_pkg::SMP_W-1:0] sample,
  output logic signed [twai_pkg::RES_W-1:0] result,
  output logic                              done
);
  import twai_pkg::*;

  logic signed [SMP_W-1:0] mem [WINDOW];
  logic signed [SMP_W-1:0] rdata;
  logic signed [SUM_W-1:0] acc;
  logic [SUM_W-1:0]        abs_full;
  logic [MAG_W-1:0]        mag;
  logic [PROD_W-1:0]       prod;
  logic                    neg;
  logic [Q_W-1:0]          quot;

  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      mem[ctrl.wr_addr] <= sample;
    end
    rdata <= mem[ctrl.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      acc <= '0;
    end else if (ctrl.acc) begin
      acc <= acc + SUM_W'(rdata);
    end
  end

  assign abs_full = acc[SUM_W-1] ? SUM_W'(-acc) : SUM_W'(acc);
  assign mag      = abs_full[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (ctrl.mul) begin
      prod <= PROD_W'(mag) * PROD_W'(ctrl.dt);
      neg  <= acc[SUM_W-1];
    end
  end

  twai_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctrl.div_start),
    .dividend ({prod, FRAC_W'(0)}),
    .divisor  (ctrl.divisor),
    .quotient (quot),
    .done     (done)
  );

  assign result = neg ? -$signed(RES_W'(quot)) : $signed(RES_W'(quot));

endmodule

// ----- src/twai_seq.sv -----
module twai_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [twai_pkg::STAMP_W-1:0]  stamp,
  input  logic [twai_pkg::LEN_W-1:0]    avg_len,
  input  logic                          div_done,
  input  logic                          out_free,
  output twai_pkg::lane_ctrl_t          ctrl,
  output twai_pkg::seq_stat_t           stat
);
  import twai_pkg::*;

  seq_state_t       state;
  seq_state_t       state_next;
  logic [PTR_W-1:0] wp;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic [STAMP_W-1:0] last_stamp;
  logic [DT_W-1:0]  dt;
  logic [LEN_W-1:0] n;
  logic [LEN_W-1:0] k;
  logic             issue_d;
  logic             zero;

  logic               accept;
  logic [STAMP_W-1:0] diff;
  logic [DT_W-1:0]    dt_next;
  logic [CNT_W-1:0]   fill_next;
  logic [CMP_W-1:0]   fill_ext;
  logic [CMP_W-1:0]   len_ext;
  logic [LEN_W-1:0]   n_next;
  logic               zero_next;
  logic [CMP_W-1:0]   cnt_ext;

  assign accept    = in_valid && (state == ST_IDLE);
  assign diff      = stamp - last_stamp;
  assign dt_next   = (diff > STAMP_W'(DT_MAX)) ? DT_MAX : diff[DT_W-1:0];
  assign fill_next = (fill < CNT_W'(WINDOW)) ? fill + 1'b1 : fill;
  assign fill_ext  = CMP_W'(fill_next);
  assign len_ext   = (avg_len == '0) ? CMP_W'(1) : CMP_W'(avg_len);
  // When clamped, the count is below the length and still fits its width.
  assign n_next    = (len_ext > fill_ext) ? fill_ext[LEN_W-1:0] : len_ext[LEN_W-1:0];
  assign zero_next = (fill_next <= CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    ctrl.wr        = accept;
    ctrl.wr_addr   = wp;
    ctrl.rd_addr   = rd_ptr;
    ctrl.clr       = accept;
    ctrl.acc       = issue_d;
    ctrl.mul       = (state == ST_MUL);
    ctrl.div_start = (state == ST_DIVS);
    ctrl.dt        = dt;
    ctrl.divisor   = DIV_W'(n) * DIV_W'(MS_PER_S);
    stat.ready     = (state == ST_IDLE);
    stat.load      = (state == ST_FIN) && out_free;
    stat.zero      = zero;
    stat.full      = (fill == CNT_W'(WINDOW));
    cnt_ext        = CMP_W'(fill);
    stat.count     = cnt_ext[CNT_OUT_W-1:0];
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = zero_next ? ST_FIN : ST_READ;
        end
      end
      ST_READ: begin
        if (k == n - 1'b1) begin
          state_next = ST_LAST;
        end
      end
      ST_LAST: state_next = ST_MUL;
      ST_MUL:  state_next = ST_DIVS;
      ST_DIVS: state_next = ST_DIVW;
      ST_DIVW: begin
        if (div_done) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp         <= '0;
      fill       <= '0;
      last_stamp <= '0;
      issue_d    <= 1'b0;
    end else begin
      issue_d <= (state == ST_READ);
      if (accept) begin
        wp         <= (wp == PTR_W'(WINDOW - 1)) ? '0 : wp + 1'b1;
        fill       <= fill_next;
        last_stamp <= stamp;
      end
    end
  end

  // The newest entry is read first, walking back through the ring.
  always_ff @(posedge clk) begin
    if (accept) begin
      dt     <= dt_next;
      n      <= n_next;
      zero   <= zero_next;
      rd_ptr <= wp;
      k      <= '0;
    end else if (state == ST_READ) begin
      k      <= k + 1'b1;
      rd_ptr <= (rd_ptr == '0) ? PTR_W'(WINDOW - 1) : rd_ptr - 1'b1;
    end
  end

endmodule

// ----- dv/tb.sv -----
module tb;
  import twai_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 600;

  typedef struct {
    logic signed [SMP_W-1:0] x;
    logic signed [SMP_W-1:0] y;
    logic signed [SMP_W-1:0] z;
    logic [STAMP_W-1:0]      stamp;
  } sample_t;

  typedef struct {
    logic signed [RES_W-1:0] incr_x;
    logic signed [RES_W-1:0] incr_y;
    logic signed [RES_W-1:0] incr_z;
    logic                    window_full;
    logic [CNT_OUT_W-1:0]    stored_count;
  } incr_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SLOW
  } rx_mode_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [79:0]  s_tdata = '0;   // sample_x, sample_y, sample_z, stamp_ms
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [135:0] m_tdata;        // incr_x, incr_y, incr_z, window_full, stored_count
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [4:0]   cfg_data = '0;

  three_axis_window_average_integrator dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Predictor state: a private copy of the sample window and the register.
  logic signed [SMP_W-1:0] win_x [WINDOW];
  logic signed [SMP_W-1:0] win_y [WINDOW];
  logic signed [SMP_W-1:0] win_z [WINDOW];
  int                      fill_cnt = 0;
  logic [STAMP_W-1:0]      prev_stamp = '0;
  logic [LEN_W-1:0]        cfg_avg_len = LEN_W'(1);

  sample_t sample_q [$];
  incr_t   pending_incr [$];
  int      n_queued = 0;
  int      n_accepted = 0;
  int      n_results = 0;
  int      n_errors = 0;
  int      n_cycles = 0;

  // Q16 of the mean of the newest n entries times dt/1000, truncated toward zero.
  function automatic longint scaled_mean(input logic signed [SMP_W-1:0] w [WINDOW],
                                         input int cnt, input int n,
                                         input longint unsigned dt);
    longint          acc;
    longint unsigned mag;
    longint unsigned q;
    acc = 0;
    for (int i = 0; i < n; i++) begin
      acc += w[cnt - 1 - i];
    end
    mag = (acc < 0) ? longint'(-acc) : longint'(acc);
    q = (mag * dt * 64'd65536) / (longint'(n) * 64'd1000);
    return (acc < 0) ? -longint'(q) : longint'(q);
  endfunction

  task automatic integrate_sample(input sample_t smp);
    logic [STAMP_W-1:0] delta;
    longint unsigned    dt;
    int                 n;
    incr_t              res;
    delta = smp.stamp - prev_stamp;
    dt = (delta > STAMP_W'(DT_MAX)) ? longint'(DT_MAX) : longint'(delta);
    prev_stamp = smp.stamp;
    if (fill_cnt < WINDOW) begin
      win_x[fill_cnt] = smp.x;
      win_y[fill_cnt] = smp.y;
      win_z[fill_cnt] = smp.z;
      fill_cnt++;
    end else begin
      for (int i = 0; i < WINDOW - 1; i++) begin
        win_x[i] = win_x[i + 1];
        win_y[i] = win_y[i + 1];
        win_z[i] = win_z[i + 1];
      end
      win_x[WINDOW - 1] = smp.x;
      win_y[WINDOW - 1] = smp.y;
      win_z[WINDOW - 1] = smp.z;
    end
    res.incr_x = '0;
    res.incr_y = '0;
    res.incr_z = '0;
    if (fill_cnt > 1) begin
      // A length of zero behaves as one; a length above the count is clamped.
      n = (cfg_avg_len == 0) ? 1 : int'(cfg_avg_len);
      if (n > fill_cnt) n = fill_cnt;
      res.incr_x = RES_W'(-scaled_mean(win_x, fill_cnt, n, dt));
      res.incr_y = RES_W'(scaled_mean(win_y, fill_cnt, n, dt));
      res.incr_z = RES_W'(scaled_mean(win_z, fill_cnt, n, dt));
    end
    res.window_full = (fill_cnt == WINDOW);
    res.stored_count = CNT_OUT_W'(fill_cnt);
    pending_incr.push_back(res);
  endtask

  // Sender: bursts of random length separated by random gaps.
  sample_t offered;
  int      burst_left;
  int      gap_left;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      burst_left = 1;
      gap_left = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        integrate_sample(offered);
        n_accepted++;
      end
      if (s_tvalid && !s_tready) begin
        // The request stays on the bus until it is taken.
      end else if (gap_left != 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (sample_q.size() != 0) begin
        offered = sample_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {offered.stamp, offered.z, offered.y, offered.x};
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end else begin
          burst_left--;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endtask

  // Receiver: its own stall pattern, plus two long hold-offs that back up the block.
  rx_mode_t rx_mode = RX_OPEN;
  int       mode_left = 0;
  int       hold_left = 0;
  int       n_holds = 0;
  logic     ready_nxt;
  incr_t    want;
  incr_t    got;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.incr_x = m_tdata[40:0];
        got.incr_y = m_tdata[81:41];
        got.incr_z = m_tdata[122:82];
        got.window_full = m_tdata[123];
        got.stored_count = m_tdata[128:124];
        if (pending_incr.size() == 0) begin
          $error("result arrived with no expectation pending");
          n_errors++;
        end else begin
          want = pending_incr.pop_front();
          check_field("incr_x", want.incr_x, got.incr_x);
          check_field("incr_y", want.incr_y, got.incr_y);
          check_field("incr_z", want.incr_z, got.incr_z);
          check_field("window_full", want.window_full, got.window_full);
          check_field("stored_count", want.stored_count, got.stored_count);
        end
        n_results++;
      end
      // A hold-off starts only while the sender still has a backlog, so the input backs up.
      if (n_holds < 2 && hold_left == 0 && n_results >= 60 + 190 * n_holds &&
          sample_q.size() >= 8) begin
        hold_left = HOLD_CYCLES;
        n_holds++;
      end
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(16, 128);
      end else begin
        mode_left--;
      end
      if (hold_left != 0) begin
        hold_left--;
        ready_nxt = 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN: ready_nxt = 1'b1;
          RX_COIN: ready_nxt = 1'($urandom_range(0, 1));
          default: ready_nxt = ($urandom_range(0, 4) == 0);
        endcase
      end
      m_tready <= ready_nxt;
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Stimulus.
  logic [STAMP_W-1:0] stamp_now = '0;
  int                 n_planned = 0;

  task automatic queue_sample(input logic [15:0] x, input logic [15:0] y,
                              input logic [15:0] z, input logic [STAMP_W-1:0] stamp);
    sample_t smp;
    smp.x = x;
    smp.y = y;
    smp.z = z;
    smp.stamp = stamp;
    stamp_now = stamp;
    sample_q.push_back(smp);
    n_queued++;
    n_planned++;
  endtask

  task automatic wait_drained();
    while (n_accepted != n_queued || pending_incr.size() != 0) @(posedge clk);
  endtask

  task automatic write_avg_len(input logic [LEN_W-1:0] len);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_avg_len = len;
  endtask

  function automatic logic [15:0] pick_axis();
    case ($urandom_range(0, 11))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [STAMP_W-1:0] next_stamp();
    case ($urandom_range(0, 19))
      0: return $urandom;
      1: return stamp_now - $urandom_range(1, 1000);
      2: return stamp_now + $urandom_range(65536, 200000);
      3: return stamp_now + 32'd65535;
      default: return stamp_now + $urandom_range(0, 200);
    endcase
  endfunction

  initial begin
    logic [LEN_W-1:0] len;
    int               phase;
    int               n_phase;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset length of one. The first request holds a single sample; then zero,
    // exact-limit and saturated time steps, and a step backward in time.
    queue_sample(16'h7FFF, 16'h8000, 16'h0000, 32'hFFFF_FFFF);
    queue_sample(16'h8000, 16'h7FFF, 16'hFFFF, 32'hFFFF_FFFF);
    queue_sample(16'h0001, 16'hFFFF, 16'h7FFF, 32'h0000_0000);
    queue_sample(16'h8000, 16'h8000, 16'h7FFF, 32'h0000_FFFF);
    queue_sample(16'h7FFF, 16'h1234, 16'h8000, 32'h0001_FFFF);
    queue_sample(16'h5A5A, 16'hA5A5, 16'h0F0F, 32'h0000_0064);

    write_avg_len(5'd0);
    queue_sample(16'h7FFF, 16'h8000, 16'h0001, 32'h0000_006E);
    queue_sample(16'hFFFF, 16'h0001, 16'h8000, 32'h0000_0456);

    // Length far above the stored count, then on past a full window with the
    // largest magnitudes and the largest time step.
    write_avg_len(5'd31);
    for (int i = 0; i < 10; i++) begin
      queue_sample(16'h8000, 16'h7FFF, 16'h8000, stamp_now + 32'd65535);
    end

    phase = 0;
    while (n_planned < 430) begin
      case (phase)
        0: len = 5'd16;
        1: len = 5'd1;
        2: len = 5'd31;
        3: len = 5'd0;
        4: len = 5'd17;
        default: len = LEN_W'($urandom_range(0, 31));
      endcase
      write_avg_len(len);
      n_phase = $urandom_range(15, 50);
      for (int i = 0; i < n_phase; i++) begin
        queue_sample(pick_axis(), pick_axis(), pick_axis(), next_stamp());
      end
      phase++;
    end

    wait_drained();
    repeat (100) @(posedge clk);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
